FILE: hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every clock edge outside reset.
`define ASSERT_CLK(name, prop, msg) \
  name: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check on every clock edge, reset included.
`define ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hdl/vswr_pkg.sv
`timescale 1ns / 1ps

package vswr_pkg;

  localparam int ADC_BITS       = 10;
  localparam int FREQ_BITS      = 27;
  localparam int VSWR_FRAC_BITS = 8;
  localparam int STEP_BITS      = 10;
  localparam int IDX_BITS       = STEP_BITS + 1;
  localparam int VSWR_BITS      = ADC_BITS + 1 + VSWR_FRAC_BITS;
  localparam int DIV_BITS       = FREQ_BITS + 1;
  localparam int DEN_BITS       = (ADC_BITS > STEP_BITS) ? ADC_BITS : STEP_BITS;
  localparam int DIV_CNT_BITS   = $clog2(DIV_BITS + 1);
  localparam int PC_BITS        = 4;

  localparam int IN_DATA_BITS   = ((2 * ADC_BITS + 7) / 8) * 8;
  localparam int OUT_FIELD_BITS = 3 * FREQ_BITS + 2 * VSWR_BITS + 2 * ADC_BITS + 1;
  localparam int OUT_DATA_BITS  = ((OUT_FIELD_BITS + 7) / 8) * 8;

  localparam logic [VSWR_BITS-1:0] VSWR_WORST    = VSWR_BITS'(999 * (2 ** VSWR_FRAC_BITS));
  localparam logic [VSWR_BITS-1:0] VSWR_MISMATCH = VSWR_BITS'(100 * (2 ** VSWR_FRAC_BITS));

  localparam logic [FREQ_BITS-1:0] START_FREQ_RESET = FREQ_BITS'(3000000);
  localparam logic [FREQ_BITS-1:0] STOP_FREQ_RESET  = FREQ_BITS'(40000000);
  localparam logic [STEP_BITS-1:0] STEP_COUNT_RESET = STEP_BITS'(50);

  typedef enum logic [1:0] {
    REG_START_FREQ,
    REG_STOP_FREQ,
    REG_STEP_COUNT
  } cfg_reg_t;

  typedef enum logic [3:0] {
    OP_LATCH,
    OP_NOP,
    OP_FDIV_LOAD,
    OP_VDIV_LOAD,
    OP_DIV_STEP,
    OP_INC_SET,
    OP_MUL,
    OP_SAMPLE,
    OP_VSWR_SET,
    OP_UPDATE,
    OP_IDLE_STOP,
    OP_TUNE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_ALWAYS,
    COND_NO_INPUT,
    COND_MEASURE,
    COND_NO_SAMPLE,
    COND_DIV_MORE,
    COND_MISMATCH,
    COND_OUT_BUSY
  } cond_t;

  typedef logic [PC_BITS-1:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  localparam pc_t PC_FETCH     = 4'd0;
  localparam pc_t PC_DISPATCH  = 4'd1;
  localparam pc_t PC_FDIV_LOAD = 4'd2;
  localparam pc_t PC_FDIV      = 4'd3;
  localparam pc_t PC_INC_SET   = 4'd4;
  localparam pc_t PC_MEASURE   = 4'd5;
  localparam pc_t PC_MUL_SAMP  = 4'd6;
  localparam pc_t PC_SAMPLE    = 4'd7;
  localparam pc_t PC_VDIV_LOAD = 4'd8;
  localparam pc_t PC_VDIV      = 4'd9;
  localparam pc_t PC_VSWR_SET  = 4'd10;
  localparam pc_t PC_UPDATE    = 4'd11;
  localparam pc_t PC_IDLE_STOP = 4'd12;
  localparam pc_t PC_MUL_TUNE  = 4'd13;
  localparam pc_t PC_TUNE      = 4'd14;
  localparam pc_t PC_EMIT      = 4'd15;

  // Control store. A taken condition loads target, else the step counter
  // advances; the last step wraps back to fetch.
  function automatic ucode_t ucode_rom(input pc_t pc);
    ucode_t uc;
    case (pc)
      PC_FETCH:     uc = '{OP_LATCH,     COND_NO_INPUT,  PC_FETCH};
      PC_DISPATCH:  uc = '{OP_NOP,       COND_MEASURE,   PC_MEASURE};
      PC_FDIV_LOAD: uc = '{OP_FDIV_LOAD, COND_NEVER,     PC_FETCH};
      PC_FDIV:      uc = '{OP_DIV_STEP,  COND_DIV_MORE,  PC_FDIV};
      PC_INC_SET:   uc = '{OP_INC_SET,   COND_ALWAYS,    PC_MUL_TUNE};
      PC_MEASURE:   uc = '{OP_NOP,       COND_NO_SAMPLE, PC_IDLE_STOP};
      PC_MUL_SAMP:  uc = '{OP_MUL,       COND_NEVER,     PC_FETCH};
      PC_SAMPLE:    uc = '{OP_SAMPLE,    COND_MISMATCH,  PC_VSWR_SET};
      PC_VDIV_LOAD: uc = '{OP_VDIV_LOAD, COND_NEVER,     PC_FETCH};
      PC_VDIV:      uc = '{OP_DIV_STEP,  COND_DIV_MORE,  PC_VDIV};
      PC_VSWR_SET:  uc = '{OP_VSWR_SET,  COND_NEVER,     PC_FETCH};
      PC_UPDATE:    uc = '{OP_UPDATE,    COND_ALWAYS,    PC_MUL_TUNE};
      PC_IDLE_STOP: uc = '{OP_IDLE_STOP, COND_NEVER,     PC_FETCH};
      PC_MUL_TUNE:  uc = '{OP_MUL,       COND_NEVER,     PC_FETCH};
      PC_TUNE:      uc = '{OP_TUNE,      COND_NEVER,     PC_FETCH};
      PC_EMIT:      uc = '{OP_EMIT,      COND_OUT_BUSY,  PC_EMIT};
      default:      uc = '{OP_NOP,       COND_ALWAYS,    PC_FETCH};
    endcase
    return uc;
  endfunction

endpackage

FILE: hdl/vswr_frequency_sweep.sv
`timescale 1ns / 1ps
// Antenna VSWR sweep. A start request (tuser 0) computes the frequency step
// from the configured start, stop and step count, resets the minimum search
// and returns the first tune frequency; each measure request (tuser 1) turns
// a forward/reverse detector pair into VSWR in Q.8, tracks the lowest value
// and its frequency, and returns the next tune frequency. Work is done by a
// 16-step microprogram over one shared restoring divider that retires one
// quotient bit per cycle. A start divides to find the frequency step; a
// measurement divides for VSWR unless the reverse level is not below
// forward, and skips it when no sample is taken. One request is in work at
// a time; the next request is taken while the previous result still waits
// in the output register.
`include "assert_macros.svh"

module vswr_frequency_sweep import vswr_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write port
  input  logic                     cfg_we,
  input  logic [1:0]               cfg_index,
  input  logic [FREQ_BITS-1:0]     cfg_data,
  // request stream
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [IN_DATA_BITS-1:0]  s_tdata,   // forward_level, reverse_level
  input  logic                     s_tuser,   // action
  // result stream
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // sample_frequency, vswr_q8, forward_echo, reverse_echo, best_vswr_q8,
  // best_frequency, tune_frequency, scan_active
  output logic [OUT_DATA_BITS-1:0] m_tdata,
  output logic                     m_tuser,   // sample_valid
  output logic                     m_tlast    // last_sample
);

  // configuration
  logic [FREQ_BITS-1:0] start_freq;
  logic [FREQ_BITS-1:0] stop_freq;
  logic [STEP_BITS-1:0] step_count;

  // sequencer
  pc_t    pc;
  pc_t    pc_next;
  ucode_t uc;
  logic   cond_hit;
  logic   out_busy;
  logic   emit_go;

  // sweep state
  logic [DIV_BITS-1:0]  freq_inc;
  logic                 inc_neg;
  logic [IDX_BITS-1:0]  step_index;
  logic [IDX_BITS-1:0]  index_inc;
  logic                 running;
  logic [VSWR_BITS-1:0] lowest_vswr;
  logic [FREQ_BITS-1:0] best_freq;

  // request latch
  logic                 action;
  logic [ADC_BITS-1:0]  fwd;
  logic [ADC_BITS-1:0]  rev;

  // shared divider
  logic [DIV_BITS-1:0]     div_q;
  logic [DEN_BITS-1:0]     div_rem;
  logic [DEN_BITS-1:0]     div_den;
  logic [DIV_CNT_BITS-1:0] div_cnt;
  logic [DEN_BITS:0]       div_shift;
  logic [DEN_BITS+1:0]     div_trial;

  // frequency path
  logic [DIV_BITS-1:0]           freq_diff;
  logic [DIV_BITS-1:0]           diff_mag;
  logic [FREQ_BITS+IDX_BITS-1:0] mul_full;
  logic [FREQ_BITS-1:0]          prod;
  logic [FREQ_BITS:0]            sum_full;
  logic [FREQ_BITS-1:0]          freq_sum;

  // result fields
  logic                 samp_valid;
  logic [FREQ_BITS-1:0] samp_freq;
  logic [VSWR_BITS-1:0] vswr;
  logic [ADC_BITS-1:0]  fwd_echo;
  logic [ADC_BITS-1:0]  rev_echo;
  logic                 last;
  logic [FREQ_BITS-1:0] tune_freq;

  // ---------------------------------------------------------------------
  // sequencer
  // ---------------------------------------------------------------------
  assign uc       = ucode_rom(pc);
  assign out_busy = m_tvalid && !m_tready;
  assign emit_go  = (uc.op == OP_EMIT) && !out_busy;
  assign s_tready = (uc.op == OP_LATCH) && !rst;

  always_comb begin
    case (uc.cond)
      COND_NEVER:     cond_hit = 1'b0;
      COND_ALWAYS:    cond_hit = 1'b1;
      COND_NO_INPUT:  cond_hit = !s_tvalid;
      COND_MEASURE:   cond_hit = action;
      COND_NO_SAMPLE: cond_hit = !(running && step_index <= {1'b0, step_count});
      COND_DIV_MORE:  cond_hit = (div_cnt != DIV_CNT_BITS'(1));
      COND_MISMATCH:  cond_hit = (rev >= fwd);
      COND_OUT_BUSY:  cond_hit = out_busy;
      default:        cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_next = cond_hit ? uc.target : pc + 1'b1;
  end

  // ---------------------------------------------------------------------
  // datapath helpers
  // ---------------------------------------------------------------------
  assign freq_diff = {1'b0, stop_freq} - {1'b0, start_freq};
  assign diff_mag  = freq_diff[DIV_BITS-1] ? -freq_diff : freq_diff;

  assign div_shift = {div_rem, div_q[DIV_BITS-1]};
  assign div_trial = {1'b0, div_shift} - {2'b00, div_den};

  assign mul_full  = (FREQ_BITS+IDX_BITS)'(step_index) *
                     (FREQ_BITS+IDX_BITS)'(freq_inc[FREQ_BITS-1:0]);
  assign sum_full  = {1'b0, start_freq} + {1'b0, prod};
  assign freq_sum  = sum_full[FREQ_BITS-1:0];
  assign index_inc = step_index + 1'b1;

  // ---------------------------------------------------------------------
  // control state
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      pc          <= PC_FETCH;
      div_cnt     <= '0;
      start_freq  <= START_FREQ_RESET;
      stop_freq   <= STOP_FREQ_RESET;
      step_count  <= STEP_COUNT_RESET;
      freq_inc    <= '0;
      step_index  <= '1;
      running     <= 1'b0;
      lowest_vswr <= VSWR_WORST;
      best_freq   <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      pc <= pc_next;

      if (cfg_we) begin
        case (cfg_index)
          REG_START_FREQ: start_freq <= cfg_data;
          REG_STOP_FREQ:  stop_freq  <= cfg_data;
          REG_STEP_COUNT: step_count <= cfg_data[STEP_BITS-1:0];
          default: ;
        endcase
      end

      if (emit_go) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (uc.op)
        OP_FDIV_LOAD, OP_VDIV_LOAD: begin
          div_cnt <= DIV_CNT_BITS'(DIV_BITS);
        end
        OP_DIV_STEP: begin
          div_cnt <= div_cnt - 1'b1;
        end
        OP_INC_SET: begin
          // zero step count leaves a single sample at the start frequency
          if (step_count == '0) begin
            freq_inc <= '0;
          end else begin
            freq_inc <= inc_neg ? -div_q : div_q;
          end
          step_index  <= '0;
          running     <= 1'b1;
          lowest_vswr <= VSWR_WORST;
          best_freq   <= start_freq;
        end
        OP_UPDATE: begin
          // ties go to the later sample
          if (vswr <= lowest_vswr) begin
            lowest_vswr <= vswr;
            best_freq   <= samp_freq;
          end
          step_index <= index_inc;
          if (index_inc > {1'b0, step_count}) begin
            running <= 1'b0;
          end
        end
        OP_IDLE_STOP: begin
          running <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // payload
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    case (uc.op)
      OP_LATCH: begin
        if (s_tvalid) begin
          action <= s_tuser;
          fwd    <= s_tdata[ADC_BITS-1:0];
          rev    <= s_tdata[2*ADC_BITS-1:ADC_BITS];
        end
      end
      OP_FDIV_LOAD: begin
        inc_neg <= freq_diff[DIV_BITS-1];
        div_q   <= diff_mag;
        div_rem <= '0;
        div_den <= DEN_BITS'(step_count);
      end
      OP_VDIV_LOAD: begin
        div_q   <= DIV_BITS'({({1'b0, fwd} + {1'b0, rev}), {VSWR_FRAC_BITS{1'b0}}});
        div_rem <= '0;
        div_den <= DEN_BITS'(fwd - rev);
      end
      OP_DIV_STEP: begin
        // restoring division, one quotient bit per step
        if (!div_trial[DEN_BITS+1]) begin
          div_rem <= div_trial[DEN_BITS-1:0];
          div_q   <= {div_q[DIV_BITS-2:0], 1'b1};
        end else begin
          div_rem <= div_shift[DEN_BITS-1:0];
          div_q   <= {div_q[DIV_BITS-2:0], 1'b0};
        end
      end
      OP_INC_SET, OP_IDLE_STOP: begin
        samp_valid <= 1'b0;
        samp_freq  <= '0;
        vswr       <= '0;
        fwd_echo   <= '0;
        rev_echo   <= '0;
        last       <= 1'b0;
      end
      OP_MUL: begin
        prod <= mul_full[FREQ_BITS-1:0];
      end
      OP_SAMPLE: begin
        samp_valid <= 1'b1;
        samp_freq  <= freq_sum;
        fwd_echo   <= fwd;
        rev_echo   <= rev;
        last       <= 1'b0;
      end
      OP_VSWR_SET: begin
        vswr <= (rev >= fwd) ? VSWR_MISMATCH : div_q[VSWR_BITS-1:0];
      end
      OP_UPDATE: begin
        last <= (index_inc > {1'b0, step_count});
      end
      OP_TUNE: begin
        tune_freq <= running ? freq_sum : '0;
      end
      OP_EMIT: begin
        if (!out_busy) begin
          m_tuser <= samp_valid;
          m_tlast <= last;
          m_tdata <= OUT_DATA_BITS'({running, tune_freq, best_freq, lowest_vswr,
                                     rev_echo, fwd_echo, vswr, samp_freq});
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------
  `ASSERT_CLK(a_div_only_in_loop, (div_cnt != '0) |-> (pc == PC_FDIV || pc == PC_VDIV),
    "divider counting outside a divide step")
  `ASSERT_CLK(a_accept_dispatch, (s_tvalid && s_tready) |=> (pc == PC_DISPATCH),
    "accepted request not dispatched")
  `ASSERT_CLK(a_last_is_sample, (m_tvalid && m_tlast) |-> (m_tuser && !m_tdata[OUT_FIELD_BITS-1]),
    "last flag without a sample or with scan still active")
  `ASSERT_ALWAYS(a_reset_clears, $past(rst) |-> (pc == PC_FETCH && !m_tvalid),
    "sequencer not idle after reset")

endmodule

FILE: bench/vswr_frequency_sweep_tb.sv
`timescale 1ns / 1ps

module vswr_frequency_sweep_tb;
  import vswr_pkg::*;

  localparam logic ACT_START   = 1'b0;
  localparam logic ACT_MEASURE = 1'b1;
  localparam int   FREQ_TOP    = 125000000;
  localparam int   STALL_LIMIT = 4000;
  localparam int   ITEM_GOAL   = 1800;

  typedef struct packed {
    logic                 active;
    logic [FREQ_BITS-1:0] tune;
    logic [FREQ_BITS-1:0] best_freq;
    logic [VSWR_BITS-1:0] best_vswr;
    logic [ADC_BITS-1:0]  rev_echo;
    logic [ADC_BITS-1:0]  fwd_echo;
    logic [VSWR_BITS-1:0] vswr;
    logic [FREQ_BITS-1:0] freq;
  } sweep_word_t;

  typedef struct {
    logic        sample_valid;
    logic        last;
    sweep_word_t word;
  } sweep_result_t;

  logic                     clk;
  logic                     rst;
  logic                     cfg_we;
  logic [1:0]               cfg_index;
  logic [FREQ_BITS-1:0]     cfg_data;
  logic                     s_tvalid;
  logic                     s_tready;
  logic [IN_DATA_BITS-1:0]  s_tdata;   // forward_level, reverse_level
  logic                     s_tuser;   // action
  logic                     m_tvalid;
  logic                     m_tready;
  // sample_frequency, vswr_q8, forward_echo, reverse_echo, best_vswr_q8,
  // best_frequency, tune_frequency, scan_active
  logic [OUT_DATA_BITS-1:0] m_tdata;
  logic                     m_tuser;   // sample_valid
  logic                     m_tlast;   // last_sample

  vswr_frequency_sweep u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast)
  );

  // sweep predictor state
  logic [FREQ_BITS-1:0] cfg_start;
  logic [FREQ_BITS-1:0] cfg_stop;
  logic [STEP_BITS-1:0] cfg_steps;
  longint               freq_increment;
  logic [IDX_BITS-1:0]  step_idx;
  logic [VSWR_BITS-1:0] best_vswr;
  logic [FREQ_BITS-1:0] best_freq;
  logic                 running;

  sweep_result_t pending_sweep_results[$];
  int            idle_pct;
  int            hold_cycles;
  int            items_sent;
  int            mismatches;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  function automatic logic [FREQ_BITS-1:0] sweep_freq_at(input logic [IDX_BITS-1:0] idx);
    return FREQ_BITS'(longint'(cfg_start) + longint'(idx) * freq_increment);
  endfunction

  function automatic sweep_result_t predict_sweep_step(input logic act,
                                                       input logic [ADC_BITS-1:0] fwd,
                                                       input logic [ADC_BITS-1:0] rev);
    sweep_result_t        res;
    longint               span;
    int                   num;
    logic [VSWR_BITS-1:0] v;
    logic [FREQ_BITS-1:0] f;
    res.sample_valid = 1'b0;
    res.last         = 1'b0;
    res.word         = '0;
    if (act == ACT_START) begin
      span           = longint'(cfg_stop) - longint'(cfg_start);
      freq_increment = (cfg_steps != 0) ? span / longint'(cfg_steps) : 0;
      step_idx       = '0;
      best_vswr      = VSWR_WORST;
      best_freq      = cfg_start;
      running        = 1'b1;
    end else if (running && step_idx <= {1'b0, cfg_steps}) begin
      f = sweep_freq_at(step_idx);
      if (rev >= fwd) begin
        v = VSWR_MISMATCH;
      end else begin
        num = (int'(fwd) + int'(rev)) << VSWR_FRAC_BITS;
        v   = VSWR_BITS'(num / (int'(fwd) - int'(rev)));
      end
      // ties move the minimum to the later sample
      if (v <= best_vswr) begin
        best_vswr = v;
        best_freq = f;
      end
      step_idx          = step_idx + 1'b1;
      res.sample_valid  = 1'b1;
      res.word.freq     = f;
      res.word.vswr     = v;
      res.word.fwd_echo = fwd;
      res.word.rev_echo = rev;
      if (step_idx > {1'b0, cfg_steps}) begin
        res.last = 1'b1;
        running  = 1'b0;
      end
    end else begin
      running = 1'b0;
    end
    res.word.best_vswr = best_vswr;
    res.word.best_freq = best_freq;
    res.word.tune      = running ? sweep_freq_at(step_idx) : '0;
    res.word.active    = running;
    return res;
  endfunction

  task automatic send_request(input logic act, input logic [ADC_BITS-1:0] fwd,
                              input logic [ADC_BITS-1:0] rev);
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= act;
    s_tdata  <= IN_DATA_BITS'({rev, fwd});
    do @(posedge clk); while (!s_tready);
    pending_sweep_results.push_back(predict_sweep_step(act, fwd, rev));
    items_sent++;
  endtask

  task automatic write_reg(input cfg_reg_t idx, input logic [FREQ_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_START_FREQ: cfg_start = value;
      REG_STOP_FREQ:  cfg_stop  = value;
      REG_STEP_COUNT: cfg_steps = value[STEP_BITS-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Hold the sender until every result is back, then let the block settle.
  task automatic wait_results_done();
    s_tvalid <= 1'b0;
    while (pending_sweep_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic pick_levels(output logic [ADC_BITS-1:0] fwd, output logic [ADC_BITS-1:0] rev);
    fwd = ADC_BITS'($urandom_range(1023));
    case ($urandom_range(9))
      0: rev = fwd;
      1: rev = ADC_BITS'($urandom_range(1023, fwd));
      2: rev = (fwd == 0) ? '0 : fwd - 1'b1;
      3, 4: rev = ADC_BITS'($urandom_range(fwd / 8));
      5, 6: rev = ADC_BITS'($urandom_range(fwd));
      default: rev = ADC_BITS'($urandom_range(1023));
    endcase
  endtask

  task automatic random_config();
    if ($urandom_range(3) != 0) write_reg(REG_START_FREQ, FREQ_BITS'($urandom_range(FREQ_TOP)));
    if ($urandom_range(3) != 0) write_reg(REG_STOP_FREQ, FREQ_BITS'($urandom_range(FREQ_TOP)));
    case ($urandom_range(9))
      0:       write_reg(REG_STEP_COUNT, FREQ_BITS'(0));
      1:       write_reg(REG_STEP_COUNT, FREQ_BITS'($urandom_range(60, 13)));
      default: write_reg(REG_STEP_COUNT, FREQ_BITS'($urandom_range(12, 1)));
    endcase
  endtask

  task automatic test_idle_measure();
    send_request(ACT_MEASURE, 10'h3FF, 10'h000);
  endtask

  task automatic test_extreme_levels();
    send_request(ACT_START, 10'h3FF, 10'h3FF);
    send_request(ACT_MEASURE, 10'd1023, 10'd0);
    send_request(ACT_MEASURE, 10'd1023, 10'd1022);
    send_request(ACT_MEASURE, 10'd0, 10'd0);
    send_request(ACT_MEASURE, 10'd900, 10'd1000);
    send_request(ACT_MEASURE, 10'd500, 10'd0);
    send_request(ACT_MEASURE, 10'd600, 10'd200);
  endtask

  task automatic test_single_point();
    wait_results_done();
    write_reg(REG_START_FREQ, FREQ_BITS'(7000000));
    write_reg(REG_STEP_COUNT, FREQ_BITS'(0));
    send_request(ACT_START, 10'd0, 10'd0);
    send_request(ACT_MEASURE, 10'd700, 10'd100);
    send_request(ACT_MEASURE, 10'd700, 10'd100);
  endtask

  task automatic test_downward();
    wait_results_done();
    write_reg(REG_START_FREQ, FREQ_BITS'(FREQ_TOP));
    write_reg(REG_STOP_FREQ, FREQ_BITS'(0));
    write_reg(REG_STEP_COUNT, FREQ_BITS'(2));
    send_request(ACT_START, 10'd0, 10'd0);
    send_request(ACT_MEASURE, 10'd300, 10'd100);
    send_request(ACT_MEASURE, 10'd300, 10'd20);
    send_request(ACT_MEASURE, 10'd300, 10'd150);
  endtask

  task automatic test_midsweep_change();
    wait_results_done();
    write_reg(REG_START_FREQ, FREQ_BITS'(0));
    write_reg(REG_STOP_FREQ, FREQ_BITS'(FREQ_TOP));
    write_reg(REG_STEP_COUNT, FREQ_BITS'(1023));
    send_request(ACT_START, 10'd0, 10'd0);
    send_request(ACT_MEASURE, 10'd512, 10'd256);
    send_request(ACT_MEASURE, 10'd512, 10'd255);
    // lower the step count below the index: the next measure stops the sweep
    wait_results_done();
    write_reg(REG_STEP_COUNT, FREQ_BITS'(1));
    send_request(ACT_MEASURE, 10'd512, 10'd100);
    // raise start after the increment is fixed: the sample frequency wraps
    wait_results_done();
    write_reg(REG_START_FREQ, FREQ_BITS'(0));
    send_request(ACT_START, 10'd0, 10'd0);
    send_request(ACT_MEASURE, 10'd800, 10'd10);
    wait_results_done();
    write_reg(REG_START_FREQ, FREQ_BITS'(FREQ_TOP));
    send_request(ACT_MEASURE, 10'd800, 10'd10);
  endtask

  task automatic run_sweeps(input int item_count);
    int                  goal;
    int                  n;
    int                  style;
    int                  i;
    logic [ADC_BITS-1:0] fwd;
    logic [ADC_BITS-1:0] rev;
    goal = items_sent + item_count;
    while (items_sent < goal) begin
      wait_results_done();
      random_config();
      pick_levels(fwd, rev);
      send_request(ACT_START, fwd, rev);
      style = $urandom_range(9);
      n = cfg_steps + 1;
      if (style == 0) n = $urandom_range(cfg_steps);
      else if (style == 1) n = n + $urandom_range(3, 1);
      for (i = 0; i < n; i++) begin
        if (style == 2 && i == n / 2) begin
          wait_results_done();
          random_config();
        end
        pick_levels(fwd, rev);
        // restart in the middle of a sweep
        if (style == 3 && i == n / 2) send_request(ACT_START, fwd, rev);
        else send_request(ACT_MEASURE, fwd, rev);
      end
    end
  endtask

  task automatic test_output_stall();
    logic [ADC_BITS-1:0] fwd;
    logic [ADC_BITS-1:0] rev;
    int                  i;
    wait_results_done();
    write_reg(REG_STEP_COUNT, FREQ_BITS'(15));
    send_request(ACT_START, 10'd0, 10'd0);
    hold_cycles = 400;
    for (i = 0; i < 16; i++) begin
      pick_levels(fwd, rev);
      send_request(ACT_MEASURE, fwd, rev);
    end
    wait_results_done();
  endtask

  // result sink
  initial begin
    m_tready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        m_tready <= 1'b0;
        hold_cycles--;
      end else begin
        m_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  task automatic check_field(input string name, input logic [63:0] want,
                             input logic [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : check_results
    sweep_result_t want;
    sweep_word_t   got;
    if (!rst && m_tvalid && m_tready) begin
      got = sweep_word_t'(m_tdata[$bits(sweep_word_t)-1:0]);
      if (pending_sweep_results.size() == 0) begin
        $error("result with no request outstanding");
        mismatches++;
      end else begin
        want = pending_sweep_results.pop_front();
        check_field("sample_valid", 64'(want.sample_valid), 64'(m_tuser));
        check_field("sample_frequency", 64'(want.word.freq), 64'(got.freq));
        check_field("vswr_q8", 64'(want.word.vswr), 64'(got.vswr));
        check_field("forward_echo", 64'(want.word.fwd_echo), 64'(got.fwd_echo));
        check_field("reverse_echo", 64'(want.word.rev_echo), 64'(got.rev_echo));
        check_field("best_vswr_q8", 64'(want.word.best_vswr), 64'(got.best_vswr));
        check_field("best_frequency", 64'(want.word.best_freq), 64'(got.best_freq));
        check_field("last_sample", 64'(want.last), 64'(m_tlast));
        check_field("tune_frequency", 64'(want.word.tune), 64'(got.tune));
        check_field("scan_active", 64'(want.word.active), 64'(got.active));
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
        if (quiet >= STALL_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  initial begin
    rst            = 1'b1;
    cfg_we         = 1'b0;
    cfg_index      = REG_START_FREQ;
    cfg_data       = '0;
    s_tvalid       = 1'b0;
    s_tdata        = '0;
    s_tuser        = ACT_START;
    idle_pct       = 35;
    hold_cycles    = 0;
    items_sent     = 0;
    mismatches     = 0;
    cfg_start      = START_FREQ_RESET;
    cfg_stop       = STOP_FREQ_RESET;
    cfg_steps      = STEP_COUNT_RESET;
    freq_increment = 0;
    step_idx       = '1;
    best_vswr      = VSWR_WORST;
    best_freq      = '0;
    running        = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_idle_measure();
    test_extreme_levels();
    test_single_point();
    test_downward();
    test_midsweep_change();
    run_sweeps(ITEM_GOAL * 6 / 10);
    idle_pct = 0;
    run_sweeps(ITEM_GOAL / 6);
    idle_pct = 35;
    test_output_stall();
    run_sweeps(ITEM_GOAL / 6);

    s_tvalid <= 1'b0;
    while (pending_sweep_results.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
